// ===== rtl/tgq_pkg.sv =====
// ----------------------------------------------------------------------------
// tgq_pkg
// Shared widths, codes, payload types and corner tables of the glyph quad
// layout block.
// ----------------------------------------------------------------------------
package tgq_pkg;

    // field widths
    localparam int OP_W      = 1;
    localparam int CHAR_W    = 8;
    localparam int ORIGIN_W  = 16;
    localparam int ALIGN_W   = 2;
    localparam int LEN_W     = 12;
    localparam int LINES_W   = 13;
    localparam int VERTEX_W  = 16;
    localparam int CELL_W    = 8;
    localparam int GLYPH_W   = 11;
    localparam int ATLAS_W   = 9;
    localparam int WRAP_W    = 12;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 12;

    // serial multiplier: multiplicand, product and step counter widths
    localparam int MUL_A_W   = LINES_W;
    localparam int PROD_W    = MUL_A_W + GLYPH_W;
    localparam int MUL_CNT_W = $clog2(GLYPH_W + 1);

    // serial divider step counter
    localparam int DIV_CNT_W = $clog2(CHAR_W + 1);

    // item codes
    localparam logic [OP_W-1:0]   OP_START = 1'b0;
    localparam logic [OP_W-1:0]   OP_CHAR  = 1'b1;
    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;

    // alignment codes
    localparam logic [ALIGN_W-1:0] ALIGN_NEAR   = 2'd0;
    localparam logic [ALIGN_W-1:0] ALIGN_CENTER = 2'd1;
    localparam logic [ALIGN_W-1:0] ALIGN_FAR    = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ATLAS_CELLS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WRAP_COLUMNS = 2'd2;

    // reset values of the registers
    localparam logic [GLYPH_W-1:0] GLYPH_SIZE_RST = 11'd16;
    localparam logic [ATLAS_W-1:0] ATLAS_CELLS_RST = 9'd16;
    localparam logic [WRAP_W-1:0]  WRAP_COLUMNS_RST = 12'd80;

    // corners of a quad, two triangles
    localparam int CORNER_IDX_W = 3;
    localparam logic [CORNER_IDX_W-1:0] CORNER_LAST = 3'd5;

    // atlas cell of one glyph
    typedef struct packed {
        logic [CELL_W-1:0] col;
        logic [CELL_W-1:0] row;
    } t_cell;

    // corner at the right edge of the cell
    function automatic logic corner_right(input logic [CORNER_IDX_W-1:0] k);
        logic r;
        case (k)
            3'd2, 3'd3, 3'd4: r = 1'b1;
            default:          r = 1'b0;
        endcase
        return r;
    endfunction

    // corner at the lower edge of the cell
    function automatic logic corner_lower(input logic [CORNER_IDX_W-1:0] k);
        logic r;
        case (k)
            3'd1, 3'd3, 3'd5: r = 1'b1;
            default:          r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/tgq_in_if.sv =====
// ----------------------------------------------------------------------------
// tgq_in_if
// Input channel: start items and character items with valid/ready.
// ----------------------------------------------------------------------------
interface tgq_in_if;
    logic                                valid;
    logic                                ready;
    logic [tgq_pkg::OP_W-1:0]            op;
    logic [tgq_pkg::CHAR_W-1:0]          char_code;
    logic [tgq_pkg::ORIGIN_W-1:0]        origin_x;
    logic [tgq_pkg::ORIGIN_W-1:0]        origin_y;
    logic [tgq_pkg::ALIGN_W-1:0]         h_align;
    logic [tgq_pkg::ALIGN_W-1:0]         v_align;
    logic [tgq_pkg::LEN_W-1:0]           text_length;
    logic [tgq_pkg::LINES_W-1:0]         line_count;

    modport source (
        output valid, op, char_code, origin_x, origin_y, h_align, v_align,
               text_length, line_count,
        input  ready
    );

    modport sink (
        input  valid, op, char_code, origin_x, origin_y, h_align, v_align,
               text_length, line_count,
        output ready
    );
endinterface

// ===== rtl/tgq_out_if.sv =====
// ----------------------------------------------------------------------------
// tgq_out_if
// Output channel: one quad corner per item with valid/ready.
// ----------------------------------------------------------------------------
interface tgq_out_if;
    logic                                valid;
    logic                                ready;
    logic [tgq_pkg::VERTEX_W-1:0]        vertex_x;
    logic [tgq_pkg::VERTEX_W-1:0]        vertex_y;
    logic [tgq_pkg::CELL_W-1:0]          cell_col;
    logic [tgq_pkg::CELL_W-1:0]          cell_row;
    logic                                u_step;
    logic                                v_step;
    logic                                last;

    modport source (
        output valid, vertex_x, vertex_y, cell_col, cell_row, u_step, v_step, last,
        input  ready
    );

    modport sink (
        input  valid, vertex_x, vertex_y, cell_col, cell_row, u_step, v_step, last,
        output ready
    );
endinterface

// ===== rtl/tgq_serial_mul.sv =====
// ----------------------------------------------------------------------------
// tgq_serial_mul
// Shift-and-add multiplier, one bit of the glyph size per cycle, msb first.
// ----------------------------------------------------------------------------
module tgq_serial_mul (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [tgq_pkg::MUL_A_W-1:0]       i_a,
    input  logic [tgq_pkg::GLYPH_W-1:0]       i_b,
    output logic                              o_done,
    output logic [tgq_pkg::PROD_W-1:0]        o_prod
);

    logic                              r_busy;
    logic [tgq_pkg::MUL_CNT_W-1:0]     r_cnt;
    logic                              r_done;
    logic [tgq_pkg::PROD_W-1:0]        r_acc;
    logic [tgq_pkg::MUL_A_W-1:0]       r_a;
    logic [tgq_pkg::GLYPH_W-1:0]       r_b;
    logic [tgq_pkg::PROD_W-1:0]        n_acc;

    // one partial product per step
    always_comb begin
        n_acc = (r_acc << 1)
              + (r_b[tgq_pkg::GLYPH_W-1] ? tgq_pkg::PROD_W'(r_a) : '0);
    end

    // step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= tgq_pkg::MUL_CNT_W'(tgq_pkg::GLYPH_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - tgq_pkg::MUL_CNT_W'(1);
                if (r_cnt == tgq_pkg::MUL_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // operand and accumulator shift
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_a   <= i_a;
            r_b   <= i_b;
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_b   <= r_b << 1;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

// ===== rtl/tgq_serial_div.sv =====
// ----------------------------------------------------------------------------
// tgq_serial_div
// Restoring divider of the character code by the atlas size, one quotient
// bit per cycle; gives the atlas cell column (remainder) and row (quotient).
// ----------------------------------------------------------------------------
module tgq_serial_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [tgq_pkg::CHAR_W-1:0]        i_dividend,
    input  logic [tgq_pkg::ATLAS_W-1:0]       i_divisor,
    output logic                              o_done,
    output tgq_pkg::t_cell                    o_cell
);

    logic                              r_busy;
    logic [tgq_pkg::DIV_CNT_W-1:0]     r_cnt;
    logic                              r_done;
    logic [tgq_pkg::ATLAS_W-1:0]       r_rem;
    logic [tgq_pkg::CHAR_W-1:0]        r_dvd;
    logic [tgq_pkg::CHAR_W-1:0]        r_quo;
    logic [tgq_pkg::ATLAS_W-1:0]       r_dvs;
    logic [tgq_pkg::ATLAS_W:0]         trial;
    logic                              fits;
    logic [tgq_pkg::ATLAS_W:0]         diff;

    // trial subtract of the divisor from the partial remainder
    always_comb begin
        trial = {r_rem, r_dvd[tgq_pkg::CHAR_W-1]};
        fits  = (trial >= {1'b0, r_dvs});
        diff  = trial - {1'b0, r_dvs};
    end

    // step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= tgq_pkg::DIV_CNT_W'(tgq_pkg::CHAR_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - tgq_pkg::DIV_CNT_W'(1);
                if (r_cnt == tgq_pkg::DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // remainder and quotient shift
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvd <= i_dividend;
            r_quo <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= fits ? diff[tgq_pkg::ATLAS_W-1:0] : trial[tgq_pkg::ATLAS_W-1:0];
            r_dvd <= r_dvd << 1;
            r_quo <= {r_quo[tgq_pkg::CHAR_W-2:0], fits};
        end
    end

    // remainder never exceeds the dividend, so its low bits hold it
    assign o_done     = r_done;
    assign o_cell.col = r_rem[tgq_pkg::CELL_W-1:0];
    assign o_cell.row = r_quo;

endmodule

// ===== rtl/text_glyph_quad_layout_core.sv =====
// ----------------------------------------------------------------------------
// text_glyph_quad_layout_core
// Lays out a string of character bytes as screen quads, six corners a glyph.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries items: a start item (op 0) sets the line origin and places
//   the pen from the alignments, text length and line count; a character
//   item (op 1) moves the pen and, unless it is a newline, yields six corner
//   items on o_out, the sixth flagged by last.
//   The config port (i_cfg_we, i_cfg_idx, i_cfg_data) writes glyph size,
//   atlas cells per row and wrap columns; write only while the block is idle.
//   One item is worked on at a time; i_in.ready is high while idle.
//   Start item: the 11-step shift-add multipliers form text length and
//   line count times the glyph size, from which the pen is placed.
//   Character item: the 8-step bit-serial atlas divider, then six corners,
//   one per cycle into the output register while the receiver takes them.
//   Newline: moves the pen to the next line and yields no corners.
//   A stalled receiver holds the corner in the output register and the
//   emission waits; the next input item can be taken once the sixth
//   corner is loaded, while it still waits to be taken.
//   Reset (synchronous, active low) restores the register defaults and
//   clears pen, line origin and column count.
// ----------------------------------------------------------------------------
module text_glyph_quad_layout_core #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [tgq_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [tgq_pkg::CFG_DAT_W-1:0]     i_cfg_data,
    tgq_in_if.sink                            i_in,
    tgq_out_if.source                         o_out
);

    localparam int CW    = COORD_WIDTH;
    localparam int DX_W  = tgq_pkg::PROD_W + 1;
    localparam int SUM_W = 34;

    // state codes
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    logic [1:0]                          r_state;
    logic [tgq_pkg::GLYPH_W-1:0]         r_glyph;
    logic [tgq_pkg::ATLAS_W-1:0]         r_atlas;
    logic [tgq_pkg::WRAP_W-1:0]          r_wrap;
    logic [CW-1:0]                       r_line_x;
    logic [CW-1:0]                       r_pen_x;
    logic [CW-1:0]                       r_pen_y;
    logic [tgq_pkg::WRAP_W-1:0]          r_col_cnt;
    logic [tgq_pkg::CORNER_IDX_W-1:0]    r_corner;
    logic                                r_out_valid;

    // latched item payload
    logic [tgq_pkg::ORIGIN_W-1:0]        r_ox;
    logic [tgq_pkg::ORIGIN_W-1:0]        r_oy;
    logic [tgq_pkg::ALIGN_W-1:0]         r_ha;
    logic [tgq_pkg::ALIGN_W-1:0]         r_va;
    logic [tgq_pkg::CHAR_W-1:0]          r_code;
    tgq_pkg::t_cell                      r_cell;

    // output register payload
    logic [tgq_pkg::VERTEX_W-1:0]        r_vx;
    logic [tgq_pkg::VERTEX_W-1:0]        r_vy;
    tgq_pkg::t_cell                      r_out_cell;
    logic                                r_u;
    logic                                r_v;
    logic                                r_last;

    logic                                in_fire;
    logic                                is_start;
    logic                                is_newline;
    logic                                do_wrap;
    logic                                out_free;
    logic [CW-1:0]                       glyph_cw;
    logic                                mul_done_l;
    logic                                mul_done_n;
    logic [tgq_pkg::PROD_W-1:0]          prod_l;
    logic [tgq_pkg::PROD_W-1:0]          prod_n;
    logic                                div_done;
    tgq_pkg::t_cell                      div_cell;
    logic [DX_W-1:0]                     dx;
    logic [DX_W-1:0]                     ox_ext;
    logic [DX_W-1:0]                     px;
    logic [tgq_pkg::PROD_W-1:0]          dy;
    logic [SUM_W-1:0]                    y_sum;
    logic [SUM_W-1:0]                    y_max;
    logic [SUM_W-1:0]                    py;
    logic                                c_right;
    logic                                c_lower;
    logic [CW-1:0]                       c_vx;
    logic [CW-1:0]                       c_vy;

    // input handshake and item decode
    assign i_in.ready = (r_state == S_IDLE);
    assign in_fire    = i_in.valid && (r_state == S_IDLE);
    assign is_start   = (i_in.op == tgq_pkg::OP_START);
    assign is_newline = (i_in.char_code == tgq_pkg::NEWLINE_CODE);
    assign do_wrap    = is_newline || (r_col_cnt >= r_wrap);
    assign glyph_cw   = CW'(r_glyph);
    assign out_free   = !r_out_valid || o_out.ready;

    // length and line count times glyph size
    tgq_serial_mul u_mul_len (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (in_fire && is_start),
        .i_a     (tgq_pkg::MUL_A_W'(i_in.text_length)),
        .i_b     (r_glyph),
        .o_done  (mul_done_l),
        .o_prod  (prod_l)
    );

    tgq_serial_mul u_mul_lines (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (in_fire && is_start),
        .i_a     (i_in.line_count),
        .i_b     (r_glyph),
        .o_done  (mul_done_n),
        .o_prod  (prod_n)
    );

    // atlas cell of the character
    tgq_serial_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (in_fire && !is_start && !is_newline),
        .i_dividend (i_in.char_code),
        .i_divisor  (r_atlas),
        .o_done     (div_done),
        .o_cell     (div_cell)
    );

    // pen placement from the alignments
    always_comb begin
        case (r_ha)
            tgq_pkg::ALIGN_CENTER: dx = ({1'b0, prod_l} + DX_W'(1)) >> 1;
            tgq_pkg::ALIGN_FAR:    dx = {1'b0, prod_l};
            default:               dx = '0;
        endcase
        case (r_va)
            tgq_pkg::ALIGN_CENTER: dy = prod_n >> 1;
            tgq_pkg::ALIGN_FAR:    dy = prod_n;
            default:               dy = '0;
        endcase
        ox_ext = DX_W'(r_ox);
        px     = (dx >= ox_ext) ? '0 : (ox_ext - dx);
        y_sum  = SUM_W'(r_oy) + SUM_W'(dy);
        y_max  = SUM_W'({CW{1'b1}});
        py     = (y_sum > y_max) ? y_max : y_sum;
    end

    // corner being emitted
    always_comb begin
        c_right = tgq_pkg::corner_right(r_corner);
        c_lower = tgq_pkg::corner_lower(r_corner);
        c_vx    = c_right ? (r_pen_x + glyph_cw) : r_pen_x;
        c_vy    = c_lower ? (r_pen_y - glyph_cw) : r_pen_y;
    end

    // sequencer, registers and pen state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_glyph     <= tgq_pkg::GLYPH_SIZE_RST;
            r_atlas     <= tgq_pkg::ATLAS_CELLS_RST;
            r_wrap      <= tgq_pkg::WRAP_COLUMNS_RST;
            r_line_x    <= '0;
            r_pen_x     <= '0;
            r_pen_y     <= '0;
            r_col_cnt   <= '0;
            r_corner    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    tgq_pkg::CFG_GLYPH_SIZE:   r_glyph <= tgq_pkg::GLYPH_W'(i_cfg_data);
                    tgq_pkg::CFG_ATLAS_CELLS:  r_atlas <= tgq_pkg::ATLAS_W'(i_cfg_data);
                    tgq_pkg::CFG_WRAP_COLUMNS: r_wrap  <= i_cfg_data;
                    default: ;
                endcase
            end

            // output valid: set when a corner is loaded, cleared when taken
            if (r_state == S_EMIT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        if (is_start) begin
                            r_line_x  <= CW'(i_in.origin_x);
                            r_col_cnt <= '0;
                            r_state   <= S_MUL;
                        end else begin
                            if (do_wrap) begin
                                r_pen_x   <= r_line_x;
                                r_pen_y   <= r_pen_y - glyph_cw;
                                r_col_cnt <= '0;
                            end
                            if (!is_newline) begin
                                r_state <= S_DIV;
                            end
                        end
                    end
                end
                S_MUL: begin
                    if (mul_done_l && mul_done_n) begin
                        r_pen_x <= CW'(px);
                        r_pen_y <= CW'(py);
                        r_state <= S_IDLE;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_corner <= '0;
                        r_state  <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        if (r_corner == tgq_pkg::CORNER_LAST) begin
                            r_pen_x   <= r_pen_x + glyph_cw;
                            r_col_cnt <= r_col_cnt + tgq_pkg::WRAP_W'(1);
                            r_corner  <= '0;
                            r_state   <= S_IDLE;
                        end else begin
                            r_corner <= r_corner + tgq_pkg::CORNER_IDX_W'(1);
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // item payload latches
    always_ff @(posedge i_clk) begin
        if (in_fire && is_start) begin
            r_ox <= i_in.origin_x;
            r_oy <= i_in.origin_y;
            r_ha <= i_in.h_align;
            r_va <= i_in.v_align;
        end
        if (in_fire && !is_start) begin
            r_code <= i_in.char_code;
        end
        if (r_state == S_DIV && div_done) begin
            if (r_atlas == '0) begin
                r_cell.col <= r_code;
                r_cell.row <= '0;
            end else begin
                r_cell <= div_cell;
            end
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (r_state == S_EMIT && out_free) begin
            r_vx       <= tgq_pkg::VERTEX_W'(c_vx);
            r_vy       <= tgq_pkg::VERTEX_W'(c_vy);
            r_out_cell <= r_cell;
            r_u        <= c_right;
            r_v        <= c_lower;
            r_last     <= (r_corner == tgq_pkg::CORNER_LAST);
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.vertex_x = r_vx;
    assign o_out.vertex_y = r_vy;
    assign o_out.cell_col = r_out_cell.col;
    assign o_out.cell_row = r_out_cell.row;
    assign o_out.u_step   = r_u;
    assign o_out.v_step   = r_v;
    assign o_out.last     = r_last;

endmodule
